@@ hdl/q8bmv_pkg.sv @@
// ----------------------------------------------------------------------------
// q8bmv_pkg
// Shared types and constants of the block-quantized matrix-vector unit.
// ----------------------------------------------------------------------------
package q8bmv_pkg;

  localparam int CMD_LOAD   = 0;
  localparam int CMD_WEIGHT = 1;

  localparam logic [47:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] ACC_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic        cmd;
    logic [11:0] act_index;
    logic signed [15:0] act_value;
    logic [15:0] block_scale;
    logic signed [7:0]  weight_lane_0;
    logic signed [7:0]  weight_lane_1;
    logic signed [7:0]  weight_lane_2;
    logic signed [7:0]  weight_lane_3;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] row_value;
    logic               row_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MUL,
    ST_ACC
  } state_t;

endpackage

@@ hdl/q8bmv_in_if.sv @@
// ----------------------------------------------------------------------------
// q8bmv_in_if
// Input channel: valid/ready handshake carrying one input item.
// ----------------------------------------------------------------------------
interface q8bmv_in_if;
  logic                 valid;
  logic                 ready;
  q8bmv_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/q8bmv_out_if.sv @@
// ----------------------------------------------------------------------------
// q8bmv_out_if
// Output channel: valid/ready handshake carrying one row result.
// ----------------------------------------------------------------------------
interface q8bmv_out_if;
  logic                 valid;
  logic                 ready;
  q8bmv_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/q8_block_matrix_vector.sv @@
// ----------------------------------------------------------------------------
// q8_block_matrix_vector
// Q8 block-quantized matrix-vector multiply with fp16 block scales.
// ----------------------------------------------------------------------------
// Usage: in_ch carries transactions. cmd 0 writes act_value into the
// activation memory at act_index. cmd 1 carries four int8 weights for the
// next four columns; the four products are summed into the block sum. A
// weight transaction occupies the block through a read step for the four
// activations and a sum step; the last group of a block adds a scale
// multiply step, then the saturating Q35.12 accumulate. After block_count
// blocks a row result is placed in the output register by the accumulate
// step of the row's last group. in_ch.ready is high only while the block
// is idle.
// cfg_we/cfg_data write block_count (reset 1, 0 acts as 1, capped at MAX_COLUMNS/BLOCK_SIZE).
// Reset clears the row state and the output; the activation memory is not
// cleared and must be written before it is read.
// A stalled receiver holds the output register; input goes on until the
// next row end, where the accumulate step waits for the register to drain.
// ----------------------------------------------------------------------------
module q8_block_matrix_vector #(
  parameter int MAX_COLUMNS = 4096,
  parameter int BLOCK_SIZE  = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  q8bmv_in_if.sink   in_ch,
  q8bmv_out_if.source out_ch
);
  localparam int LANES  = 4;
  localparam int AW     = $clog2(MAX_COLUMNS);
  localparam int CW     = AW + 1;
  localparam int BW     = $clog2(BLOCK_SIZE);
  localparam int BMAX   = MAX_COLUMNS / BLOCK_SIZE;
  localparam int WW     = (BMAX > 255) ? 9 : 8;
  localparam int SW     = 16 + 8 + BW + 1;

  logic [15:0] mem0 [MAX_COLUMNS/LANES];
  logic [15:0] mem1 [MAX_COLUMNS/LANES];
  logic [15:0] mem2 [MAX_COLUMNS/LANES];
  logic [15:0] mem3 [MAX_COLUMNS/LANES];
  logic [15:0] rd0, rd1, rd2, rd3;

  q8bmv_pkg::state_t state, state_next;
  logic [7:0]  block_count;
  logic [CW-1:0] column_counter;
  logic signed [SW-1:0] block_partial_sum;
  logic [15:0] held_scale;
  logic signed [47:0] row_accumulator;
  logic        overflow_seen;
  logic signed [7:0] w0, w1, w2, w3;
  logic        last_group;
  logic [SW+10:0] prod;
  logic        prod_neg, prod_inf;
  logic [4:0]  prod_exp;
  logic        out_valid;
  logic        acc_hold, out_load;
  q8bmv_pkg::out_item_t out_data;

  wire accept = in_ch.valid && in_ch.ready;
  wire is_w   = in_ch.data.cmd == 1'(q8bmv_pkg::CMD_WEIGHT);
  wire [AW-1:0] caddr = column_counter[AW-1:0];
  wire [AW-3:0] row_addr = caddr[AW-1:2];

  assign in_ch.ready = (state == q8bmv_pkg::ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  always_ff @(posedge clk) begin
    if (accept && !is_w && {{(32-12){1'b0}}, in_ch.data.act_index} < MAX_COLUMNS) begin
      case (in_ch.data.act_index[1:0])
        2'd0: mem0[in_ch.data.act_index[AW-1:2]] <= in_ch.data.act_value;
        2'd1: mem1[in_ch.data.act_index[AW-1:2]] <= in_ch.data.act_value;
        2'd2: mem2[in_ch.data.act_index[AW-1:2]] <= in_ch.data.act_value;
        default: mem3[in_ch.data.act_index[AW-1:2]] <= in_ch.data.act_value;
      endcase
    end
    rd0 <= mem0[row_addr];
    rd1 <= mem1[row_addr];
    rd2 <= mem2[row_addr];
    rd3 <= mem3[row_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= q8bmv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      q8bmv_pkg::ST_IDLE: if (accept && is_w) state_next = q8bmv_pkg::ST_READ;
      q8bmv_pkg::ST_READ: state_next = q8bmv_pkg::ST_SUM;
      q8bmv_pkg::ST_SUM:  state_next = last_group ? q8bmv_pkg::ST_MUL : q8bmv_pkg::ST_IDLE;
      q8bmv_pkg::ST_MUL:  state_next = q8bmv_pkg::ST_ACC;
      q8bmv_pkg::ST_ACC:  state_next = acc_hold ? q8bmv_pkg::ST_ACC : q8bmv_pkg::ST_IDLE;
      default: state_next = q8bmv_pkg::ST_IDLE;
    endcase
  end

  logic signed [SW-1:0] sum_next;
  logic [10:0] sig;
  logic [SW-1:0] mag;
  logic [WW-1:0] eff;
  logic [CW-1:0] col_after;
  logic signed [49:0] acc_sum;
  logic [SW+10+31:0] shifted;
  logic [48:0] term_mag;
  logic [5:0] rsh;
  logic row_end;

  always_comb begin
    sum_next = block_partial_sum
      + SW'(signed'(rd0) * w0) + SW'(signed'(rd1) * w1)
      + SW'(signed'(rd2) * w2) + SW'(signed'(rd3) * w3);
    sig = (held_scale[14:10] == 5'd0) ? {1'b0, held_scale[9:0]} : {1'b1, held_scale[9:0]};
    mag = block_partial_sum[SW-1] ? SW'(-block_partial_sum) : SW'(block_partial_sum);
    term_mag = '0;
    shifted = '0;
    rsh = '0;
    if (prod_exp >= 5'd13) begin
      shifted = (SW+10+32)'(prod) << (prod_exp - 5'd13);
      term_mag = (shifted[SW+10+31:48] != '0) ? {1'b1, 48'h0} : {1'b0, shifted[47:0]};
    end else begin
      rsh = (prod_exp == 5'd0) ? 6'd12 : 6'(5'd13 - prod_exp);
      shifted = ((SW+10+32)'(prod) + ((SW+10+32)'(1) << (rsh - 6'd1))) >> rsh;
      term_mag = shifted[48:0];
    end
    acc_sum = prod_neg ? 50'(row_accumulator) - 50'(term_mag)
                       : 50'(row_accumulator) + 50'(term_mag);
    eff = (block_count == 8'd0) ? WW'(1) : WW'(block_count);
    if (eff > WW'(BMAX)) eff = WW'(BMAX);
    col_after = column_counter;
    row_end = ({{(32-CW+BW){1'b0}}, col_after[CW-1:BW]} >= 32'(eff))
              || (32'(col_after) >= MAX_COLUMNS);
    acc_hold = (state == q8bmv_pkg::ST_ACC) && row_end && out_valid && !out_ch.ready;
    out_load = (state == q8bmv_pkg::ST_ACC) && row_end && !acc_hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= 8'd1;
      column_counter <= '0;
      block_partial_sum <= '0;
      held_scale <= '0;
      row_accumulator <= '0;
      overflow_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) block_count <= cfg_data;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        q8bmv_pkg::ST_IDLE: begin
          if (accept && is_w) begin
            w0 <= in_ch.data.weight_lane_0;
            w1 <= in_ch.data.weight_lane_1;
            w2 <= in_ch.data.weight_lane_2;
            w3 <= in_ch.data.weight_lane_3;
            last_group <= column_counter[BW-1:0] == BW'(BLOCK_SIZE - LANES);
            if (column_counter[BW-1:0] == '0) begin
              held_scale <= in_ch.data.block_scale;
              block_partial_sum <= '0;
            end
          end
        end
        q8bmv_pkg::ST_SUM: begin
          block_partial_sum <= sum_next;
          column_counter <= column_counter + CW'(LANES);
        end
        q8bmv_pkg::ST_MUL: begin
          prod <= (SW+11)'(mag) * (SW+11)'(sig);
          prod_neg <= held_scale[15] ^ block_partial_sum[SW-1];
          prod_exp <= held_scale[14:10];
          prod_inf <= held_scale[14:10] == 5'h1F;
        end
        q8bmv_pkg::ST_ACC: begin
          logic signed [47:0] acc_new;
          logic ov;
          acc_new = row_accumulator;
          ov = overflow_seen;
          if (prod_inf) begin
            ov = 1'b1;
          end else if (acc_sum > 50'sh0_7FFF_FFFF_FFFF) begin
            acc_new = q8bmv_pkg::ACC_MAX;
            ov = 1'b1;
          end else if (acc_sum < -50'sh0_8000_0000_0000) begin
            acc_new = q8bmv_pkg::ACC_MIN;
            ov = 1'b1;
          end else begin
            acc_new = acc_sum[47:0];
          end
          if (out_load) begin
            out_data.row_value <= acc_new;
            out_data.row_overflow <= ov;
            row_accumulator <= '0;
            overflow_seen <= 1'b0;
            column_counter <= '0;
            block_partial_sum <= '0;
          end else if (!acc_hold) begin
            row_accumulator <= acc_new;
            overflow_seen <= ov;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

@@ dv/q8bmv_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// q8bmv_checker
// Watches the input, output and register ports of the matrix-vector unit,
// predicts every row result from the accepted transactions and compares
// the results field by field in order.
// ----------------------------------------------------------------------------
module q8bmv_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  q8bmv_in_if         in_ch,
  q8bmv_out_if        out_ch,
  output int          errors,
  output int          pending
);

  localparam int       COLS     = 4096;
  localparam int       BLK      = 32;
  localparam int       MAX_BLKS = COLS / BLK;
  localparam longint   SUM_HI   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint   SUM_LO   = -SUM_HI - 1;

  logic [15:0] act_mem [COLS];
  int unsigned col_cnt;
  longint      blk_sum;
  logic [15:0] scale_q;
  longint      row_acc;
  bit          row_ovf;
  logic [7:0]  blk_cfg;
  q8bmv_pkg::out_item_t row_q [$];

  assign pending = row_q.size();

  task automatic apply_scale();
    logic [4:0]        e;
    longint unsigned   mag;
    longint            term;
    longint            total;
    int                sh;
    bit                neg;
    e   = scale_q[14:10];
    neg = scale_q[15];
    if (e == 5'd31) begin
      row_ovf = 1'b1;
      return;
    end
    if (blk_sum < 0) begin
      neg = !neg;
      mag = -blk_sum;
    end else begin
      mag = blk_sum;
    end
    if (e == 5'd0) begin
      mag = mag * scale_q[9:0];
      sh  = -12;
    end else begin
      mag = mag * (64'd1024 + scale_q[9:0]);
      sh  = int'(e) - 13;
    end
    if (sh >= 0) mag = mag << sh;
    else mag = (mag + (64'd1 << (-sh - 1))) >> (-sh);
    term  = neg ? -longint'(mag) : longint'(mag);
    total = row_acc + term;
    if (total > SUM_HI) begin
      total   = SUM_HI;
      row_ovf = 1'b1;
    end
    if (total < SUM_LO) begin
      total   = SUM_LO;
      row_ovf = 1'b1;
    end
    row_acc = total;
  endtask

  task automatic predict_row(input q8bmv_pkg::in_item_t it);
    int unsigned pos;
    int unsigned eff;
    logic signed [7:0] w [4];
    q8bmv_pkg::out_item_t r;
    if (it.cmd == 1'(q8bmv_pkg::CMD_LOAD)) begin
      act_mem[it.act_index] = it.act_value;
      return;
    end
    w = '{it.weight_lane_0, it.weight_lane_1, it.weight_lane_2, it.weight_lane_3};
    pos = col_cnt % BLK;
    if (pos == 0) begin
      scale_q = it.block_scale;
      blk_sum = 0;
    end
    for (int l = 0; l < 4; l++) begin
      if (col_cnt + l < COLS)
        blk_sum += longint'($signed(act_mem[col_cnt + l])) * longint'(w[l]);
    end
    col_cnt += 4;
    if (pos + 4 < BLK) return;
    apply_scale();
    eff = (blk_cfg == 0) ? 1 : blk_cfg;
    if (eff > MAX_BLKS) eff = MAX_BLKS;
    if (col_cnt / BLK < eff && col_cnt < COLS) return;
    r.row_value    = row_acc[47:0];
    r.row_overflow = row_ovf;
    row_q.push_back(r);
    row_acc = 0;
    row_ovf = 1'b0;
    col_cnt = 0;
    blk_sum = 0;
  endtask

  always @(posedge clk) begin
    q8bmv_pkg::out_item_t e;
    if (rst) begin
      col_cnt = 0;
      blk_sum = 0;
      scale_q = '0;
      row_acc = 0;
      row_ovf = 1'b0;
      blk_cfg = 8'd1;
      row_q.delete();
    end else begin
      if (cfg_we) blk_cfg = cfg_data;
      if (in_ch.valid && in_ch.ready) predict_row(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        if (row_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected row result %h", $time, out_ch.data);
        end else begin
          e = row_q.pop_front();
          if (out_ch.data.row_value !== e.row_value) begin
            errors++;
            $display("%0t: row_value expected %0d actual %0d", $time,
                     e.row_value, out_ch.data.row_value);
          end
          if (out_ch.data.row_overflow !== e.row_overflow) begin
            errors++;
            $display("%0t: row_overflow expected %0d actual %0d", $time,
                     e.row_overflow, out_ch.data.row_overflow);
          end
        end
      end
    end
  end

  initial errors = 0;

endmodule

@@ dv/q8_block_matrix_vector_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// q8_block_matrix_vector_tb
// Loads activations and streams weight rows through the matrix-vector unit
// under several block counts and random handshake gaps; the checker
// predicts and compares every row result.
// ----------------------------------------------------------------------------
module q8_block_matrix_vector_tb;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RAND_ITEMS  = 1800;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_data;
  int         errors;
  int         pending;
  int         cycles;
  int         n_rand;
  bit         in_idle;
  bit         out_idle;
  bit         written [4096];
  logic [7:0] blk_cfg;

  q8bmv_in_if  in_ch();
  q8bmv_out_if out_ch();

  q8_block_matrix_vector u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  q8bmv_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("q8_block_matrix_vector_tb failed");
      $finish;
    end
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = out_idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send(input q8bmv_pkg::in_item_t it);
    int gap;
    gap = in_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    n_rand++;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic load_act(input int idx, input logic [15:0] val);
    q8bmv_pkg::in_item_t it;
    it           = q8bmv_pkg::in_item_t'($urandom());
    it.cmd       = 1'(q8bmv_pkg::CMD_LOAD);
    it.act_index = 12'(idx);
    it.act_value = val;
    written[idx] = 1'b1;
    send(it);
  endtask

  task automatic send_group(input logic [15:0] scale, input logic [31:0] w);
    q8bmv_pkg::in_item_t it;
    it               = q8bmv_pkg::in_item_t'({$urandom(), $urandom(), $urandom()});
    it.cmd           = 1'(q8bmv_pkg::CMD_WEIGHT);
    it.block_scale   = scale;
    it.weight_lane_0 = w[7:0];
    it.weight_lane_1 = w[15:8];
    it.weight_lane_2 = w[23:16];
    it.weight_lane_3 = w[31:24];
    send(it);
  endtask

  function automatic logic [15:0] rand_act();
    case ($urandom_range(0, 5))
      0: rand_act = 16'h7FFF;
      1: rand_act = 16'h8000;
      2: rand_act = 16'($urandom_range(0, 255) - 128);
      default: rand_act = 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] rand_scale();
    logic [15:0] s;
    s = 16'($urandom());
    if ($urandom_range(0, 1)) s[14:10] = 5'($urandom_range(0, 18));
    rand_scale = s;
  endfunction

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] val);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= val;
    blk_cfg  = val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic int eff_blocks();
    eff_blocks = (blk_cfg == 0) ? 1 : (blk_cfg > 128) ? 128 : blk_cfg;
  endfunction

  task automatic fill_columns(input int cols);
    for (int c = 0; c < cols; c++)
      if (!written[c]) load_act(c, rand_act());
  endtask

  task automatic directed_row(input logic [15:0] scale, input logic [31:0] w);
    fill_columns(eff_blocks() * 32);
    for (int g = 0; g < eff_blocks() * 8; g++) send_group(scale, w);
  endtask

  task automatic random_row();
    int cols;
    cols = eff_blocks() * 32;
    fill_columns(cols);
    for (int g = 0; g < cols / 4; g++) begin
      if ($urandom_range(0, 7) == 0) begin
        load_act($urandom_range(0, 4095), rand_act());
      end
      send_group(rand_scale(), $urandom());
    end
  endtask

  initial begin
    logic [7:0] phases [7];
    phases = '{8'd0, 8'd2, 8'd6, 8'd5, 8'd1, 8'd3, 8'd8};
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    blk_cfg     = 8'd1;
    cycles      = 0;
    n_rand      = 0;
    in_idle     = 1'b1;
    out_idle    = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int c = 0; c < 32; c++) load_act(c, (c == 31) ? 16'h8000 : 16'h7FFF);
    directed_row(16'h7BFF, 32'h7F7F7F7F);
    directed_row(16'hFBFF, 32'h7F7F7F7F);
    directed_row(16'h7C00, $urandom());
    directed_row(16'hFE01, 32'h80808080);
    directed_row(16'h8001, 32'h80808080);
    directed_row(16'h0000, $urandom());
    directed_row(16'h03FF, $urandom());
    load_act(4095, 16'h8000);

    for (int p = 0; n_rand < RAND_ITEMS; p = (p + 1) % 7) begin
      write_cfg(phases[p]);
      in_idle  = $urandom_range(0, 3) != 0;
      out_idle = $urandom_range(0, 3) != 0;
      if (eff_blocks() == 128) random_row();
      else repeat ($urandom_range(3, 8)) random_row();
    end
    in_ch.valid <= 1'b0;
    wait_idle();
    if (errors == 0) begin
      $display("q8_block_matrix_vector_tb passed");
    end else begin
      $display("q8_block_matrix_vector_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/q8bmv_pkg.sv
hdl/q8bmv_in_if.sv
hdl/q8bmv_out_if.sv
hdl/q8_block_matrix_vector.sv
dv/q8bmv_checker.sv
dv/q8_block_matrix_vector_tb.sv
